>>> hw/rtl/bcsg_pkg.sv
`timescale 1ns / 1ps

package bcsg_pkg;

    localparam int GRID_MAX  = 32;
    localparam int AXIS_W    = $clog2(GRID_MAX);
    localparam int ADDR_W    = 3 * AXIS_W;
    localparam int SIZE_W    = 6;
    localparam int CELL_W    = 40;
    localparam int CHARGE_W  = 24;
    localparam int WEIGHT_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int ORDER     = 4;
    localparam int OFF_W     = 2;
    localparam int IDX_W     = 3 * OFF_W;
    localparam int THETA_W   = ORDER * WEIGHT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = ADDR_W;

    // pipeline stages behind the issue cycle
    localparam int PIPE_DRAIN = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(GRID_MAX);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

    localparam logic FUNC_SPREAD = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [IDX_W-1:0]  idx;
        logic              clear_we;
        logic [ADDR_W-1:0] clear_addr;
    } bcsg_cmd_t;

endpackage

>>> hw/rtl/bspline_charge_spread_grid_core.sv
`timescale 1ns / 1ps

// order-4 b-spline charge spreading into a 32x32x32 grid of signed 40-bit cells
// input items: start with func, base_x/y/z, charge, theta_*_packed; accepted
//   on a rising edge where start is high and busy is low
// spread item (func 0): adds charge*wx*wy*wz into up to 64 cells, no result;
//   busy from the accepting edge through 64 read-modify-writes, one per
//   cycle on the grid memory, and the drain of the 3 pipeline stages; zero
//   charge is taken with no busy time at all
// read item (func 1): returns the cell in cell_value with done high for one
//   cycle, and clears the cell; busy through the read and the pipeline drain
// a new item is taken only after the last one has drained and busy is low
// the receiver cannot stall: done is a one-cycle strobe and must be taken
// config channel: cfg_valid/cfg_ready with cfg_index (0 x, 1 y, 2 z size) and
//   cfg_data; cfg_ready is always high; write only while busy is low
// reset: sizes go to 32, then a clearing pass zeros all 32768 grid cells, one
//   per cycle, with busy high; config writes are still taken
module bspline_charge_spread_grid_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_x,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_y,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_z,
    input  logic signed [bcsg_pkg::CHARGE_W-1:0] charge,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_x_packed,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_y_packed,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_z_packed,
    // result
    output logic                                 done,
    output logic signed [bcsg_pkg::CELL_W-1:0]   cell_value,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcsg_pkg::SIZE_W-1:0]          cfg_data
);
    import bcsg_pkg::*;

    bcsg_cmd_t cmd;
    logic      charge_zero;

    // zero charge touches nothing, so the controller skips the spread
    assign charge_zero = (charge == '0);

    // sizes are plain registers, a write always completes
    assign cfg_ready = 1'b1;

    bcsg_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .charge_zero (charge_zero),
        .busy        (busy),
        .cmd         (cmd)
    );

    // datapath: wrap and address, three multiplies, memory read, saturating add or read-and-clear
    bcsg_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .base_x         (base_x),
        .base_y         (base_y),
        .base_z         (base_z),
        .charge         (charge),
        .theta_x_packed (theta_x_packed),
        .theta_y_packed (theta_y_packed),
        .theta_z_packed (theta_z_packed),
        .done           (done),
        .cell_value     (cell_value)
    );

endmodule

>>> hw/rtl/bcsg_ctrl.sv
`timescale 1ns / 1ps

module bcsg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                func,
    input  logic                charge_zero,
    output logic                busy,
    output bcsg_pkg::bcsg_cmd_t cmd
);
    import bcsg_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SPREAD = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    localparam logic [IDX_W-1:0] IDX_LAST = '1;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we   = 1'b1;
                cmd.clear_addr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (func == FUNC_READ)
                        state_next = ST_READ;
                    else if (!charge_zero)
                        state_next = ST_SPREAD;
                end
            end
            ST_SPREAD:
            begin
                cmd.issue = 1'b1;
                cmd.idx   = cnt_reg[IDX_W-1:0];
                if (cnt_reg[IDX_W-1:0] == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_DRAIN;
                cnt_next   = '0;
            end
            ST_DRAIN:
            begin
                if (cnt_reg == CNT_W'(PIPE_DRAIN - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> hw/rtl/bcsg_datapath.sv
`timescale 1ns / 1ps

module bcsg_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bcsg_pkg::bcsg_cmd_t                  cmd,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcsg_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                 func,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_x,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_y,
    input  logic [bcsg_pkg::AXIS_W-1:0]          base_z,
    input  logic signed [bcsg_pkg::CHARGE_W-1:0] charge,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_x_packed,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_y_packed,
    input  logic [bcsg_pkg::THETA_W-1:0]         theta_z_packed,
    output logic                                 done,
    output logic signed [bcsg_pkg::CELL_W-1:0]   cell_value
);
    import bcsg_pkg::*;

    localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
    localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

    function automatic logic [SIZE_W-1:0] wrap_axis(input logic [AXIS_W-1:0] b,
                                                    input logic [OFF_W-1:0] off,
                                                    input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] s;
        s = SIZE_W'(b) + SIZE_W'(off);
        if (s >= n)
            s = s - n;
        return s;
    endfunction

    // grid sizes
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_X: size_x_reg <= cfg_data;
                CFG_GRID_Y: size_y_reg <= cfg_data;
                CFG_GRID_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // item latch
    logic                       func_reg;
    logic [AXIS_W-1:0]          bx_reg, by_reg, bz_reg;
    logic signed [CHARGE_W-1:0] charge_reg;
    logic [THETA_W-1:0]         thx_reg, thy_reg, thz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            bx_reg     <= base_x;
            by_reg     <= base_y;
            bz_reg     <= base_z;
            charge_reg <= charge;
            thx_reg    <= theta_x_packed;
            thy_reg    <= theta_y_packed;
            thz_reg    <= theta_z_packed;
        end
    end

    // stage 0: coordinates, weight select, wz*wy
    logic [OFF_W-1:0]      off_i, off_j, off_k;
    logic [SIZE_W-1:0]     cx, cy, cz;
    logic [WEIGHT_W-1:0]   wx0, wy0, wz0;
    logic [2*WEIGHT_W-1:0] wzy;
    logic                  ok0;
    logic [ADDR_W-1:0]     addr0;

    assign off_i = cmd.idx[OFF_W-1:0];
    assign off_j = cmd.idx[2*OFF_W-1:OFF_W];
    assign off_k = cmd.idx[3*OFF_W-1:2*OFF_W];

    always_comb
    begin
        if (func_reg == FUNC_READ)
        begin
            cx = SIZE_W'(bx_reg);
            cy = SIZE_W'(by_reg);
            cz = SIZE_W'(bz_reg);
        end
        else
        begin
            cx = wrap_axis(bx_reg, off_i, size_x_reg);
            cy = wrap_axis(by_reg, off_j, size_y_reg);
            cz = wrap_axis(bz_reg, off_k, size_z_reg);
        end
    end

    assign wx0   = thx_reg[{off_i, 4'b0000} +: WEIGHT_W];
    assign wy0   = thy_reg[{off_j, 4'b0000} +: WEIGHT_W];
    assign wz0   = thz_reg[{off_k, 4'b0000} +: WEIGHT_W];
    assign wzy   = wz0 * wy0;
    assign ok0   = (cx < SIZE_W'(GRID_MAX)) && (cy < SIZE_W'(GRID_MAX))
                   && (cz < SIZE_W'(GRID_MAX));
    assign addr0 = {cx[AXIS_W-1:0], cy[AXIS_W-1:0], cz[AXIS_W-1:0]};

    // stage registers
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       ok1_reg, ok2_reg, ok3_reg;
    logic                       rd1_reg, rd2_reg, rd3_reg;
    logic [ADDR_W-1:0]          addr1_reg, addr2_reg, addr3_reg;
    logic [WEIGHT_W-1:0]        t1_reg, wx1_reg, wx2_reg;
    logic signed [CHARGE_W-1:0] vprod2_reg, c3_reg;
    logic signed [CELL_W-1:0]   rdata_reg;
    logic                       fwd_hit_reg;
    logic signed [CELL_W-1:0]   fwd_data_reg;
    logic                       done_reg;
    logic signed [CELL_W-1:0]   value_reg;

    logic signed [CHARGE_W+WEIGHT_W:0] prod_v, prod_c;
    logic signed [CELL_W-1:0]          old_val, sat_val, wdata3;
    logic signed [CELL_W:0]            sum3;
    logic                              we3;

    assign prod_v = charge_reg * $signed({1'b0, t1_reg});
    assign prod_c = vprod2_reg * $signed({1'b0, wx2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            fwd_hit_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            v1_reg      <= cmd.issue;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            // a write lands on the same edge as the next read of that cell
            fwd_hit_reg <= we3 && (addr3_reg == addr2_reg);
            done_reg    <= v3_reg && rd3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg      <= ok0;
        rd1_reg      <= func_reg;
        addr1_reg    <= addr0;
        t1_reg       <= wzy[2*WEIGHT_W-1:FRAC_W];
        wx1_reg      <= wx0;

        ok2_reg      <= ok1_reg;
        rd2_reg      <= rd1_reg;
        addr2_reg    <= addr1_reg;
        vprod2_reg   <= prod_v[CHARGE_W+FRAC_W-1:FRAC_W];
        wx2_reg      <= wx1_reg;

        ok3_reg      <= ok2_reg;
        rd3_reg      <= rd2_reg;
        addr3_reg    <= addr2_reg;
        c3_reg       <= prod_c[CHARGE_W+FRAC_W-1:FRAC_W];

        fwd_data_reg <= wdata3;
        value_reg    <= old_val;
    end

    // stage 3: saturating accumulate, or read and clear
    assign old_val = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign sum3    = {old_val[CELL_W-1], old_val}
                     + {{(CELL_W+1-CHARGE_W){c3_reg[CHARGE_W-1]}}, c3_reg};

    always_comb
    begin
        if (sum3[CELL_W] != sum3[CELL_W-1])
            sat_val = sum3[CELL_W] ? CELL_MIN : CELL_MAX;
        else
            sat_val = sum3[CELL_W-1:0];
    end

    assign wdata3 = rd3_reg ? '0 : sat_val;
    assign we3    = v3_reg && ok3_reg;

    // grid store
    logic signed [CELL_W-1:0] grid_mem [GRID_MAX*GRID_MAX*GRID_MAX];

    always_ff @(posedge clk)
    begin
        if (cmd.clear_we)
            grid_mem[cmd.clear_addr] <= '0;
        else if (we3)
            grid_mem[addr3_reg] <= wdata3;
        rdata_reg <= grid_mem[addr2_reg];
    end

    assign done       = done_reg;
    assign cell_value = value_reg;

endmodule

>>> hw/rtl/bcsg_checker.sv
`timescale 1ns / 1ps

module bcsg_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              func,
    input logic signed [bcsg_pkg::CHARGE_W-1:0] charge,
    input logic                              done
);
    import bcsg_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // a read item always gives its result with a done strobe
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_READ) |-> ##5 done)
        else $error("read result not on time");

    // a result only follows busy time
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // results are single-cycle strobes
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a spread item with charge keeps the block busy through all 64 cells
    a_spread_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_SPREAD) && (charge != '0) |-> ##67 busy)
        else $error("spread ended early");

    // and frees it right after
    a_spread_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_SPREAD) && (charge != '0) |-> ##68 !busy)
        else $error("spread ran too long");

endmodule

bind bspline_charge_spread_grid_core bcsg_checker u_bcsg_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .charge (charge),
    .done   (done)
);

>>> tb/sv/bspline_charge_spread_grid_core_tb.sv
`timescale 1ns / 1ps

module bspline_charge_spread_grid_core_tb;

    import bcsg_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int REPORT_MAX  = 10;
    localparam int SETTLE_CYC  = PIPE_DRAIN + 4;

    // index outside the register map, the block drops the write
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [THETA_W-1:0] THETA_ONES = '1;
    localparam logic [THETA_W-1:0] THETA_ZERO = '0;

    // saturation bounds of one cell
    localparam longint CELL_HI = (longint'(1) <<< (CELL_W - 1)) - 1;
    localparam longint CELL_LO = -(longint'(1) <<< (CELL_W - 1));

    typedef struct {
        logic                       f;
        logic [AXIS_W-1:0]          bx;
        logic [AXIS_W-1:0]          by;
        logic [AXIS_W-1:0]          bz;
        logic signed [CHARGE_W-1:0] chg;
        logic [THETA_W-1:0]         tx;
        logic [THETA_W-1:0]         ty;
        logic [THETA_W-1:0]         tz;
    } grid_item_t;

    // one row of the directed table; fixed rows carry a hand-written cell value
    typedef struct {
        grid_item_t                 item;
        bit                         fixed;
        logic signed [CELL_W-1:0]   fixed_val;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       func;
    logic [AXIS_W-1:0]          base_x;
    logic [AXIS_W-1:0]          base_y;
    logic [AXIS_W-1:0]          base_z;
    logic signed [CHARGE_W-1:0] charge;
    logic [THETA_W-1:0]         theta_x_packed;
    logic [THETA_W-1:0]         theta_y_packed;
    logic [THETA_W-1:0]         theta_z_packed;
    logic                       done;
    logic signed [CELL_W-1:0]   cell_value;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [SIZE_W-1:0]          cfg_data;

    // grid copy and wrap sizes kept alongside the block
    longint                     grid_model [0:GRID_MAX*GRID_MAX*GRID_MAX-1];
    int unsigned                size_x;
    int unsigned                size_y;
    int unsigned                size_z;

    // cell values still owed by the block, oldest first
    logic signed [CELL_W-1:0]   cell_expect_q [$];
    logic signed [CELL_W-1:0]   exp_cell;

    int                         err_count;
    int                         cells_checked;
    int                         spreads_sent;
    int                         zero_spreads;
    int                         reads_sent;
    int                         size_settings;
    int                         cycle_count;

    // last spread base, used to aim reads at cells that hold charge
    int unsigned                last_bx;
    int unsigned                last_by;
    int unsigned                last_bz;

    bspline_charge_spread_grid_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .base_x         (base_x),
        .base_y         (base_y),
        .base_z         (base_z),
        .charge         (charge),
        .theta_x_packed (theta_x_packed),
        .theta_y_packed (theta_y_packed),
        .theta_z_packed (theta_z_packed),
        .done           (done),
        .cell_value     (cell_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog, a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d cell values pending",
                     cycle_count, cell_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // grid predictor
    // ------------------------------------------------------------------

    // one subtraction only, a coordinate far past the size stays out of range
    function automatic int unsigned wrap_coord(input int unsigned c, input int unsigned n);
        if (c >= n)
            return c - n;
        return c;
    endfunction

    function automatic int unsigned cell_addr(input int unsigned x, input int unsigned y,
                                              input int unsigned z);
        return (x * GRID_MAX + y) * GRID_MAX + z;
    endfunction

    task automatic set_grid_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        case (idx)
            CFG_GRID_X: size_x = val;
            CFG_GRID_Y: size_y = val;
            CFG_GRID_Z: size_z = val;
            default: ;
        endcase
    endtask

    // applies one accepted item to the grid copy, a read returns the cell and clears it
    task automatic grid_apply(input grid_item_t it, output bit has_out,
                              output logic signed [CELL_W-1:0] out_val);
        int unsigned gx;
        int unsigned gy;
        int unsigned gz;
        int unsigned a;
        longint      wx;
        longint      wy;
        longint      wz;
        longint      t;
        longint      v;
        longint      c;
        longint      s;
        has_out = 1'b0;
        out_val = '0;
        if (it.f == FUNC_READ)
        begin
            a = cell_addr(it.bx, it.by, it.bz);
            out_val = grid_model[a][CELL_W-1:0];
            grid_model[a] = 0;
            has_out = 1'b1;
        end
        else if (it.chg != 0)
        begin
            for (int k = 0; k < ORDER; k++)
            begin
                gz = wrap_coord(int'(it.bz) + k, size_z);
                wz = longint'(it.tz[WEIGHT_W*k +: WEIGHT_W]);
                for (int j = 0; j < ORDER; j++)
                begin
                    gy = wrap_coord(int'(it.by) + j, size_y);
                    wy = longint'(it.ty[WEIGHT_W*j +: WEIGHT_W]);
                    // weight product, then charge, then x weight, each floored
                    t = (wz * wy) >>> FRAC_W;
                    v = (longint'(it.chg) * t) >>> FRAC_W;
                    for (int i = 0; i < ORDER; i++)
                    begin
                        gx = wrap_coord(int'(it.bx) + i, size_x);
                        wx = longint'(it.tx[WEIGHT_W*i +: WEIGHT_W]);
                        c = (v * wx) >>> FRAC_W;
                        // contributions that land past the store are lost
                        if (gx < GRID_MAX && gy < GRID_MAX && gz < GRID_MAX)
                        begin
                            a = cell_addr(gx, gy, gz);
                            s = grid_model[a] + c;
                            if (s > CELL_HI)
                                s = CELL_HI;
                            else if (s < CELL_LO)
                                s = CELL_LO;
                            grid_model[a] = s;
                        end
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // item driver
    // ------------------------------------------------------------------

    // start stays high on return so a back-to-back item never drops it
    task automatic drive_item(input grid_item_t it, input bit fixed,
                              input logic signed [CELL_W-1:0] fixed_val);
        bit                       has_out;
        logic signed [CELL_W-1:0] val;
        start          <= 1'b1;
        func           <= it.f;
        base_x         <= it.bx;
        base_y         <= it.by;
        base_z         <= it.bz;
        charge         <= it.chg;
        theta_x_packed <= it.tx;
        theta_y_packed <= it.ty;
        theta_z_packed <= it.tz;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // accepted at this edge
        grid_apply(it, has_out, val);
        if (has_out)
            cell_expect_q.push_back(fixed ? fixed_val : val);
        if (it.f == FUNC_READ)
            reads_sent++;
        else
        begin
            spreads_sent++;
            if (it.chg == 0)
                zero_spreads++;
            last_bx = it.bx;
            last_by = it.by;
            last_bz = it.bz;
        end
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drop start, wait out every owed cell value and the pipeline tail
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (cell_expect_q.size() != 0 || busy !== 1'b0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // rewrites all three sizes while the block is idle
    task automatic write_sizes(input int unsigned sx, input int unsigned sy,
                               input int unsigned sz, input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [SIZE_W-1:0]    val [4];
        int                   cnt;
        idx[0] = CFG_GRID_X;
        val[0] = SIZE_W'(sx);
        idx[1] = CFG_GRID_Y;
        val[1] = SIZE_W'(sy);
        idx[2] = CFG_GRID_Z;
        val[2] = SIZE_W'(sz);
        idx[3] = CFG_UNUSED;
        val[3] = SIZE_W'($urandom);
        cnt = poke_unused ? 4 : 3;
        wait_idle();
        for (int n = 0; n < cnt; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[n];
            cfg_data  <= val[n];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            set_grid_size(idx[n], val[n]);
        end
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------

    task automatic random_item(output grid_item_t it);
        int unsigned x;
        int unsigned y;
        int unsigned z;
        int          r;
        it.f  = ($urandom_range(0, 99) < 55) ? FUNC_SPREAD : FUNC_READ;
        it.bx = AXIS_W'($urandom);
        it.by = AXIS_W'($urandom);
        it.bz = AXIS_W'($urandom);
        r = $urandom_range(0, 9);
        case (r)
            0:       it.chg = '0;
            1:       it.chg = {1'b0, {(CHARGE_W-1){1'b1}}};
            2:       it.chg = {1'b1, {(CHARGE_W-1){1'b0}}};
            3:       it.chg = CHARGE_W'($urandom_range(0, 8)) - CHARGE_W'(4);
            default: it.chg = CHARGE_W'($urandom);
        endcase
        r = $urandom_range(0, 11);
        it.tx = (r == 0) ? THETA_ONES : (r == 1) ? THETA_ZERO : {$urandom, $urandom};
        it.ty = (r == 2) ? THETA_ONES : (r == 3) ? THETA_ZERO : {$urandom, $urandom};
        it.tz = (r == 4) ? THETA_ONES : (r == 5) ? THETA_ZERO : {$urandom, $urandom};
        // most reads land inside the footprint of the last spread
        if (it.f == FUNC_READ && $urandom_range(0, 9) < 7)
        begin
            x = wrap_coord(last_bx + $urandom_range(0, ORDER - 1), size_x);
            y = wrap_coord(last_by + $urandom_range(0, ORDER - 1), size_y);
            z = wrap_coord(last_bz + $urandom_range(0, ORDER - 1), size_z);
            if (x < GRID_MAX)
                it.bx = AXIS_W'(x);
            if (y < GRID_MAX)
                it.by = AXIS_W'(y);
            if (z < GRID_MAX)
                it.bz = AXIS_W'(z);
        end
    endtask

    // bursts of items, gaps short, long or absent, now and then a full drain
    task automatic run_random(input int n_items);
        grid_item_t it;
        int         sent;
        int         burst;
        int         r;
        sent = 0;
        while (sent < n_items)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < n_items; b++)
            begin
                random_item(it);
                drive_item(it, 1'b0, '0);
                sent++;
            end
            r = $urandom_range(0, 29);
            if (r == 0)
                wait_idle();
            else if (r < 10)
                idle_for(0);
            else if (r < 20)
                idle_for($urandom_range(1, 4));
            else if (r < 26)
                idle_for($urandom_range(5, 30));
            else
                idle_for($urandom_range(31, 90));
        end
    endtask

    // ------------------------------------------------------------------
    // result checker, the block cannot be held off so every strobe counts
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (cell_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("cell_value %0d strobed with nothing pending", cell_value);
            end
            else
            begin
                exp_cell = cell_expect_q.pop_front();
                cells_checked++;
                if (cell_value !== exp_cell)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("cell_value mismatch: expected %0d got %0d",
                                 exp_cell, cell_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------

    function automatic dir_row_t read_row(input int unsigned x, input int unsigned y,
                                          input int unsigned z, input bit fixed,
                                          input longint v);
        dir_row_t r;
        r.item.f   = FUNC_READ;
        r.item.bx  = AXIS_W'(x);
        r.item.by  = AXIS_W'(y);
        r.item.bz  = AXIS_W'(z);
        r.item.chg = '0;
        r.item.tx  = THETA_ZERO;
        r.item.ty  = THETA_ZERO;
        r.item.tz  = THETA_ZERO;
        r.fixed    = fixed;
        r.fixed_val = CELL_W'(v);
        return r;
    endfunction

    function automatic dir_row_t spread_row(input int unsigned x, input int unsigned y,
                                            input int unsigned z,
                                            input logic [CHARGE_W-1:0] chg,
                                            input logic [THETA_W-1:0] tx,
                                            input logic [THETA_W-1:0] ty,
                                            input logic [THETA_W-1:0] tz);
        dir_row_t r;
        r.item.f   = FUNC_SPREAD;
        r.item.bx  = AXIS_W'(x);
        r.item.by  = AXIS_W'(y);
        r.item.bz  = AXIS_W'(z);
        r.item.chg = chg;
        r.item.tx  = tx;
        r.item.ty  = ty;
        r.item.tz  = tz;
        r.fixed    = 1'b0;
        r.fixed_val = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        dir_row_t rows [$];

        rst_n          <= 1'b0;
        start          <= 1'b0;
        func           <= FUNC_SPREAD;
        base_x         <= '0;
        base_y         <= '0;
        base_z         <= '0;
        charge         <= '0;
        theta_x_packed <= '0;
        theta_y_packed <= '0;
        theta_z_packed <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_GRID_X;
        cfg_data       <= '0;
        err_count      = 0;
        cells_checked  = 0;
        spreads_sent   = 0;
        zero_spreads   = 0;
        reads_sent     = 0;
        size_settings  = 1;
        cycle_count    = 0;
        last_bx        = 0;
        last_by        = 0;
        last_bz        = 0;
        size_x         = GRID_MAX;
        size_y         = GRID_MAX;
        size_z         = GRID_MAX;
        foreach (grid_model[a])
            grid_model[a] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // sit out the clearing pass
        repeat (2) @(posedge clk);
        do
            @(posedge clk);
        while (busy !== 1'b0);

        // cleared grid reads zero at both corners
        rows.push_back(read_row(0, 0, 0, 1'b1, 0));
        rows.push_back(read_row(31, 31, 31, 1'b1, 0));
        // zero charge leaves the cell alone
        rows.push_back(spread_row(0, 0, 0, '0, THETA_ONES, THETA_ONES, THETA_ONES));
        rows.push_back(read_row(0, 0, 0, 1'b1, 0));
        // largest positive charge, full weights, then read twice to see the clear
        rows.push_back(spread_row(0, 0, 0, 24'h7FFFFF, THETA_ONES, THETA_ONES, THETA_ONES));
        rows.push_back(read_row(0, 0, 0, 1'b0, 0));
        rows.push_back(read_row(3, 3, 3, 1'b0, 0));
        rows.push_back(read_row(0, 0, 0, 1'b1, 0));
        // most negative charge at the top corner, footprint wraps on every axis
        rows.push_back(spread_row(30, 30, 30, 24'h800000, THETA_ONES, THETA_ONES,
                                  THETA_ONES));
        rows.push_back(read_row(31, 31, 31, 1'b0, 0));
        rows.push_back(read_row(1, 1, 1, 1'b0, 0));
        rows.push_back(read_row(30, 0, 1, 1'b0, 0));
        rows.push_back(read_row(30, 30, 30, 1'b0, 0));
        // tiny negative charge, floors toward minus infinity
        rows.push_back(spread_row(5, 6, 7, 24'hFFFFFF, 64'h0001_0001_0001_0001,
                                  THETA_ONES, THETA_ONES));
        rows.push_back(read_row(5, 6, 7, 1'b0, 0));
        // unit charge with a distinct weight per slot in x and z
        rows.push_back(spread_row(9, 9, 9, 24'h010000, 64'h2000_4000_8000_FFFF,
                                  64'hFFFF_0000_FFFF_0000, 64'h0001_7FFF_8000_FFFF));
        rows.push_back(read_row(9, 9, 9, 1'b0, 0));
        rows.push_back(read_row(12, 9, 9, 1'b0, 0));
        rows.push_back(read_row(9, 10, 9, 1'b0, 0));
        // zero weights add nothing even with charge
        rows.push_back(spread_row(20, 20, 20, 24'h123456, THETA_ZERO, THETA_ZERO, THETA_ZERO));
        rows.push_back(read_row(20, 20, 20, 1'b1, 0));
        // two spreads on one footprint accumulate
        rows.push_back(spread_row(14, 15, 16, 24'h7FFFFF, THETA_ONES, THETA_ONES, THETA_ONES));
        rows.push_back(spread_row(14, 15, 16, 24'h654321, THETA_ONES, THETA_ONES, THETA_ONES));
        rows.push_back(read_row(15, 16, 17, 1'b0, 0));

        foreach (rows[n])
            drive_item(rows[n].item, rows[n].fixed, rows[n].fixed_val);

        // default sizes
        run_random(90);
        // smallest legal grid, most bases sit in the padding; stray index poked too
        write_sizes(4, 4, 4, 1'b1);
        run_random(80);
        // uneven grid
        write_sizes(17, 5, 32, 1'b0);
        run_random(80);
        // zero size never wraps, oversize pushes the footprint off the store
        write_sizes(0, 63, 33, 1'b0);
        run_random(70);
        write_sizes(63, 0, 4, 1'b1);
        run_random(80);

        wait_idle();

        if (cell_expect_q.size() != 0)
        begin
            err_count += cell_expect_q.size();
            $display("%0d cell values never arrived", cell_expect_q.size());
        end

        $display("covered %0d spreads (%0d with zero charge) and %0d reads over %0d size settings",
                 spreads_sent, zero_spreads, reads_sent, size_settings);
        $display("%0d cell values checked, %0d mismatches in %0d cycles",
                 cells_checked, err_count, cycle_count);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
